[rtl/dcls_pkg.sv]
// ----------------------------------------------------------------------------
// dcls_pkg
// Shared types and constants for the daily count log store.
// ----------------------------------------------------------------------------
package dcls_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PG_W        = ((ADDR_W > 10) ? ADDR_W : 10) + 2;

  localparam int LOG_START   = 12;
  localparam int SCAN_START  = 13;
  localparam int TOT_BYTES   = 12;

  localparam logic [7:0] EMPTY_MARK = 8'd254;
  localparam logic [7:0] MAX_COUNT  = 8'd253;
  localparam logic [7:0] OUT_MARK   = 8'hFF;

  localparam int REQ_W       = 3;
  localparam int COUNT_W     = 16;
  localparam int PAGE_W      = 8;
  localparam int TOTAL_W     = 32;
  localparam int DAY_PTR_W   = 10;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [2:0] {
    REQ_NEW_DAY     = 3'd0,
    REQ_STORE_TODAY = 3'd1,
    REQ_READ_PAGE   = 3'd2,
    REQ_READ_TOTAL  = 3'd3,
    REQ_STORE_TOTAL = 3'd4,
    REQ_CLEAR       = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_STW0,
    S_STW1,
    S_PG_RD,
    S_PG_LD,
    S_TOT_RD,
    S_TOT_TAIL,
    S_TOT_OUT,
    S_TOTW,
    S_CLR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADDR_CNT,
    ADDR_SLOT,
    ADDR_SLOT1,
    ADDR_PAGE
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_COUNT,
    WR_MARK,
    WR_TOTAL
  } wr_sel_t;

  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_TOTAL,
    OUT_BYTE
  } out_sel_t;

  typedef struct packed {
    logic      latch;
    logic      cnt_ld;
    logic      cnt_scan;
    logic      cnt_inc;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      slot_hit;
    logic      slot_wrap;
    logic      tot_shift;
    logic      out_ld;
    out_sel_t  out_sel;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic cnt_clr_end;
    logic cnt_tot_end;
    logic pg_last;
    logic rd_hit;
    logic rd_scan_end;
    logic out_free;
  } sts_t;

endpackage

[rtl/daily_count_log_store.sv]
// A new day scans the log with one byte read per cycle until it finds the empty mark or the end.
// Throughput: one request at a time; the next is taken once the last beat is loaded.
// Reset: synchronous rst_n clears control; a clearing pass then writes the cleared pattern
//   to all STORE_BYTES (1024) bytes while in_tready stays low.
// ----------------------------------------------------------------------------
// daily_count_log_store
// Byte store with triplicated total count and a daily count log.
// ----------------------------------------------------------------------------
module daily_count_log_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dcls_pkg::IN_TDATA_W-1:0]      in_tdata,   // day_count, page_number, total_value
  input  logic [dcls_pkg::REQ_W-1:0]           in_tuser,   // req_type
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dcls_pkg::OUT_TDATA_W-1:0]     out_tdata,  // day_pointer, day_byte, total_count, pad
  output logic                                 out_tlast
);

  dcls_pkg::cmd_t cmd;
  dcls_pkg::sts_t sts;

  dcls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("store read and write in same cycle");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while request in progress");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("input ready during clearing pass");

  a_page_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[49:18] == '0))
    else $error("non-final page beat carries a total");

endmodule

[rtl/dcls_ctrl.sv]
// ----------------------------------------------------------------------------
// dcls_ctrl
// Request sequencer: clearing sweep, scan, day store, page read, total read/write.
// ----------------------------------------------------------------------------
module dcls_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic [dcls_pkg::REQ_W-1:0]     in_req,
  output logic                           in_tready,
  input  dcls_pkg::sts_t                 sts,
  output dcls_pkg::cmd_t                 cmd
);

  dcls_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcls_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcls_pkg::S_INIT: begin
        if (sts.cnt_clr_end) state_nxt = dcls_pkg::S_IDLE;
      end
      dcls_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (dcls_pkg::req_t'(in_req))
            dcls_pkg::REQ_NEW_DAY:     state_nxt = dcls_pkg::S_SCAN;
            dcls_pkg::REQ_STORE_TODAY: state_nxt = dcls_pkg::S_STW0;
            dcls_pkg::REQ_READ_PAGE:   state_nxt = dcls_pkg::S_PG_RD;
            dcls_pkg::REQ_READ_TOTAL:  state_nxt = dcls_pkg::S_TOT_RD;
            dcls_pkg::REQ_STORE_TOTAL: state_nxt = dcls_pkg::S_TOTW;
            dcls_pkg::REQ_CLEAR:       state_nxt = dcls_pkg::S_CLR;
            default:                   state_nxt = dcls_pkg::S_DONE;
          endcase
        end
      end
      dcls_pkg::S_SCAN: begin
        if (sts.rd_hit || sts.rd_scan_end) state_nxt = dcls_pkg::S_DONE;
      end
      dcls_pkg::S_STW0:  state_nxt = dcls_pkg::S_STW1;
      dcls_pkg::S_STW1:  state_nxt = dcls_pkg::S_DONE;
      dcls_pkg::S_PG_RD: state_nxt = dcls_pkg::S_PG_LD;
      dcls_pkg::S_PG_LD: begin
        if (sts.out_free) begin
          state_nxt = sts.pg_last ? dcls_pkg::S_IDLE : dcls_pkg::S_PG_RD;
        end
      end
      dcls_pkg::S_TOT_RD: begin
        if (sts.cnt_tot_end) state_nxt = dcls_pkg::S_TOT_TAIL;
      end
      dcls_pkg::S_TOT_TAIL: state_nxt = dcls_pkg::S_TOT_OUT;
      dcls_pkg::S_TOT_OUT: begin
        if (sts.out_free) state_nxt = dcls_pkg::S_IDLE;
      end
      dcls_pkg::S_TOTW: begin
        if (sts.cnt_tot_end) state_nxt = dcls_pkg::S_DONE;
      end
      dcls_pkg::S_CLR: begin
        if (sts.cnt_clr_end) state_nxt = dcls_pkg::S_DONE;
      end
      dcls_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = dcls_pkg::S_IDLE;
      end
      default: state_nxt = dcls_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = dcls_pkg::ADDR_CNT;
    cmd.wr_sel   = dcls_pkg::WR_CLEAR;
    cmd.out_sel  = dcls_pkg::OUT_PLAIN;
    in_tready    = 1'b0;
    unique case (state_r)
      dcls_pkg::S_INIT, dcls_pkg::S_CLR: begin
        cmd.mem_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      dcls_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch    = in_tvalid;
        cmd.cnt_ld   = in_tvalid;
        cmd.cnt_scan = (dcls_pkg::req_t'(in_req) == dcls_pkg::REQ_NEW_DAY);
      end
      dcls_pkg::S_SCAN: begin
        cmd.mem_rd    = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.slot_hit  = sts.rd_hit;
        cmd.slot_wrap = !sts.rd_hit && sts.rd_scan_end;
      end
      dcls_pkg::S_STW0: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = dcls_pkg::ADDR_SLOT;
        cmd.wr_sel   = dcls_pkg::WR_COUNT;
      end
      dcls_pkg::S_STW1: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = dcls_pkg::ADDR_SLOT1;
        cmd.wr_sel   = dcls_pkg::WR_MARK;
      end
      dcls_pkg::S_PG_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = dcls_pkg::ADDR_PAGE;
      end
      dcls_pkg::S_PG_LD: begin
        cmd.out_sel  = dcls_pkg::OUT_BYTE;
        cmd.out_ld   = sts.out_free;
        cmd.out_last = sts.pg_last;
        cmd.cnt_inc  = sts.out_free && !sts.pg_last;
      end
      dcls_pkg::S_TOT_RD: begin
        cmd.mem_rd    = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.tot_shift = 1'b1;
      end
      dcls_pkg::S_TOT_TAIL: begin
        cmd.tot_shift = 1'b1;
      end
      dcls_pkg::S_TOT_OUT: begin
        cmd.out_sel  = dcls_pkg::OUT_TOTAL;
        cmd.out_ld   = sts.out_free;
        cmd.out_last = 1'b1;
      end
      dcls_pkg::S_TOTW: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = dcls_pkg::WR_TOTAL;
        cmd.cnt_inc = 1'b1;
      end
      dcls_pkg::S_DONE: begin
        cmd.out_ld   = sts.out_free;
        cmd.out_last = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/dcls_dp.sv]
// ----------------------------------------------------------------------------
// dcls_dp
// Byte store, day slot, walk counter, total collector and output register.
// ----------------------------------------------------------------------------
module dcls_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dcls_pkg::cmd_t                       cmd,
  output dcls_pkg::sts_t                       sts,
  input  logic [dcls_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dcls_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast
);

  localparam int AW = dcls_pkg::ADDR_W;
  localparam int PW = dcls_pkg::PG_W;
  localparam int TB = dcls_pkg::TOT_BYTES * 8;
  localparam int OUT_USED = dcls_pkg::DAY_PTR_W + dcls_pkg::BYTE_W + dcls_pkg::TOTAL_W;

  logic [7:0] mem [dcls_pkg::STORE_BYTES];

  logic [dcls_pkg::COUNT_W-1:0] count_r;
  logic [dcls_pkg::PAGE_W-1:0]  page_r;
  logic [dcls_pkg::TOTAL_W-1:0] total_r;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] addr;
  logic [AW-1:0] rd_addr_r;
  logic          rd_vld_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    wdata;
  logic [TB-1:0] tot_buf_r;

  logic signed [PW-1:0] pg_addr;
  logic                 pg_ok;

  logic [dcls_pkg::TOTAL_W-1:0] c1, c2, c3, voted;

  logic                              out_valid_r, out_valid_nxt;
  logic [dcls_pkg::DAY_PTR_W-1:0]    out_ptr_r;
  logic [dcls_pkg::BYTE_W-1:0]       out_byte_r, out_byte_nxt;
  logic [dcls_pkg::TOTAL_W-1:0]      out_total_r, out_total_nxt;
  logic                              out_last_r;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      count_r <= in_tdata[15:0];
      page_r  <= in_tdata[23:16];
      total_r <= in_tdata[55:24];
    end
  end

  // page address: slot - 4*page - k
  always_comb begin
    pg_addr = $signed(PW'(slot_r)) - $signed(PW'({page_r, 2'b00})) - $signed(PW'(cnt_r[1:0]));
    pg_ok   = (pg_addr > $signed(PW'(dcls_pkg::LOG_START))) &&
              (pg_addr < $signed(PW'(dcls_pkg::STORE_BYTES)));
  end

  always_comb begin
    unique case (cmd.addr_sel)
      dcls_pkg::ADDR_CNT:   addr = cnt_r;
      dcls_pkg::ADDR_SLOT:  addr = slot_r;
      dcls_pkg::ADDR_SLOT1: addr = slot_r + AW'(1);
      dcls_pkg::ADDR_PAGE:  addr = pg_addr[AW-1:0];
      default:              addr = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      dcls_pkg::WR_CLEAR: wdata = (cnt_r <= AW'(dcls_pkg::LOG_START)) ? 8'd0 : dcls_pkg::EMPTY_MARK;
      dcls_pkg::WR_COUNT: wdata = (count_r > dcls_pkg::COUNT_W'(dcls_pkg::MAX_COUNT)) ?
                                  dcls_pkg::MAX_COUNT : count_r[7:0];
      dcls_pkg::WR_MARK:  wdata = dcls_pkg::EMPTY_MARK;
      dcls_pkg::WR_TOTAL: wdata = total_r[8*cnt_r[1:0] +: 8];
      default:            wdata = dcls_pkg::EMPTY_MARK;
    endcase
  end

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
      rd_addr_r <= addr;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_ld) begin
      cnt_nxt = cmd.cnt_scan ? AW'(dcls_pkg::SCAN_START) : '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.slot_hit) begin
      slot_nxt = rd_addr_r;
    end else if (cmd.slot_wrap) begin
      slot_nxt = AW'(dcls_pkg::LOG_START);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      slot_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      slot_r   <= slot_nxt;
      rd_vld_r <= cmd.mem_rd;
    end
  end

  // total collector, first byte ends up lowest
  always_ff @(posedge clk) begin
    if (cmd.tot_shift && rd_vld_r) begin
      tot_buf_r <= {rd_data_r, tot_buf_r[TB-1:8]};
    end
  end

  always_comb begin
    c1    = tot_buf_r[31:0];
    c2    = tot_buf_r[63:32];
    c3    = tot_buf_r[95:64];
    voted = c1;
    if ((c1 != c2) && (c1 != c3) && (c2 == c3)) voted = c2;
  end

  // output register
  always_comb begin
    out_byte_nxt  = '0;
    out_total_nxt = '0;
    case (cmd.out_sel)
      dcls_pkg::OUT_BYTE:  out_byte_nxt  = pg_ok ? rd_data_r : dcls_pkg::OUT_MARK;
      dcls_pkg::OUT_TOTAL: out_total_nxt = voted;
      default: begin
        out_byte_nxt  = '0;
        out_total_nxt = '0;
      end
    endcase
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_ptr_r   <= dcls_pkg::DAY_PTR_W'(slot_r);
      out_byte_r  <= out_byte_nxt;
      out_total_r <= out_total_nxt;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(dcls_pkg::OUT_TDATA_W - OUT_USED)'(0), out_total_r, out_byte_r, out_ptr_r};

  assign sts.cnt_clr_end = (cnt_r == AW'(dcls_pkg::STORE_BYTES - 1));
  assign sts.cnt_tot_end = (cnt_r == AW'(dcls_pkg::TOT_BYTES - 1));
  assign sts.pg_last     = (cnt_r[1:0] == 2'd3);
  assign sts.rd_hit      = rd_vld_r && (rd_data_r == dcls_pkg::EMPTY_MARK);
  assign sts.rd_scan_end = rd_vld_r && (rd_addr_r == AW'(dcls_pkg::STORE_BYTES - 2));
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule
